FILE: sv/sam_pkg.sv
// ----------------------------------------------------------------------------
// sam_pkg
// shared types and constants of the suffix automaton block
// ----------------------------------------------------------------------------
package sam_pkg;

	localparam int SYM_W      = 7;
	localparam int ACT_W      = 2;
	localparam int COUNT_W    = 14;
	localparam int DISTINCT_W = 24;
	localparam int QLEN_W     = 13;
	localparam int QPOS_W     = 16;

	typedef enum logic [ACT_W-1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_EXTEND = 2'd1,
		ACT_QSTART = 2'd2,
		ACT_QSYM   = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_ECHK,
		S_EWALK,
		S_EQ,
		S_EQL,
		S_ECW,
		S_EFIN,
		S_QWALK,
		S_RES
	} sam_state_t;

	// control from the sequencer to the query tracker
	typedef struct packed {
		logic              clr;
		logic              upd;
		logic [QLEN_W-1:0] len;
	} trk_ctl_t;

endpackage

FILE: sv/sam_if.sv
// ----------------------------------------------------------------------------
// sam_in_if / sam_out_if
// valid/ready channels carrying the input item and the result item
// ----------------------------------------------------------------------------
interface sam_in_if;
	import sam_pkg::*;
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [SYM_W-1:0] symbol;
	modport source (output valid, output action, output symbol, input ready);
	modport sink (input valid, input action, input symbol, output ready);
endinterface

interface sam_out_if;
	import sam_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [COUNT_W-1:0]    state_count;
	logic [DISTINCT_W-1:0] distinct_total;
	logic [QLEN_W-1:0]     match_length;
	logic [QLEN_W-1:0]     best_length;
	logic [QPOS_W-1:0]     best_end;
	logic                  table_full;
	modport source (output valid, output state_count, output distinct_total,
		output match_length, output best_length, output best_end, output table_full,
		input ready);
	modport sink (input valid, input state_count, input distinct_total,
		input match_length, input best_length, input best_end, input table_full,
		output ready);
endinterface

FILE: sv/sam_query_track.sv
// ----------------------------------------------------------------------------
// sam_query_track
// best match length, its end position and the saturating query position
// ----------------------------------------------------------------------------
module sam_query_track (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sam_pkg::trk_ctl_t        ctl,
	output logic [sam_pkg::QLEN_W-1:0] best,
	output logic [sam_pkg::QPOS_W-1:0] best_pos
);
	import sam_pkg::*;

	logic [QPOS_W-1:0] pos_q;
	logic [QLEN_W-1:0] best_q;
	logic [QPOS_W-1:0] best_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			best_q     <= '0;
			best_pos_q <= '0;
		end else if (ctl.clr) begin
			pos_q      <= '0;
			best_q     <= '0;
			best_pos_q <= '0;
		end else if (ctl.upd) begin
			if (ctl.len > best_q) begin
				best_q     <= ctl.len;
				best_pos_q <= pos_q;
			end
			// position saturates at all ones
			if (pos_q != '1)
				pos_q <= pos_q + 1'b1;
		end
	end

	assign best     = best_q;
	assign best_pos = best_pos_q;

endmodule

FILE: sv/suffix_automaton_build_and_match.sv
// ----------------------------------------------------------------------------
// suffix_automaton_build_and_match
// suffix automaton kept in one state record memory, built and matched per symbol
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one item per transfer: action and symbol. out_ch returns
//   exactly one result per item, in order, held in an output register.
//   the block takes one item at a time; in_ch.ready is high only while the
//   sequencer is idle. a result that waits on out_ch does not block the next
//   input transfer, only the delivery of that item's own result.
//   clear, start query and out-of-alphabet items go from idle straight to
//   the result state. a query symbol follows suffix links until a
//   transition is found or the root is reached. an extend checks for room,
//   walks the links adding transitions, checks q when the walk stops at an
//   existing transition and writes the new state; a refused extend goes from
//   the check to the result state. a clone writes the clone, relinks q and
//   walks the links to redirect; all walks are one memory read a cycle.
//   each record holds the whole transition row of a state plus its suffix
//   link and length, so a row clear or a clone copy is one write.
//   after reset the init state writes the root record before items are taken.
//   when out_ch stalls, the finished item waits in the result state.
// ----------------------------------------------------------------------------
module suffix_automaton_build_and_match #(
	parameter int MAX_LEN  = 4096,
	parameter int ALPHABET = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	sam_in_if.sink    in_ch,
	sam_out_if.source out_ch
);
	import sam_pkg::*;

	localparam int NSTATES = 2 * MAX_LEN;
	localparam int SW      = $clog2(NSTATES);     // state index
	localparam int CW      = SW + 1;              // state count
	localparam int LW      = $clog2(MAX_LEN + 1); // state length
	localparam int EW      = SW + 1;              // entry: valid + target
	localparam int AW      = $clog2(ALPHABET);
	localparam int ROW_W   = ALPHABET * EW;
	localparam int REC_W   = ROW_W + SW + LW;
	localparam logic [8:0] ALPHA9 = 9'(ALPHABET);

	// state record memory: row, link, length
	logic [REC_W-1:0] mem [NSTATES];
	logic [REC_W-1:0] rd_q;
	logic             we, re;
	logic [SW-1:0]    waddr, raddr;
	logic [REC_W-1:0] wdata;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rd_q <= mem[raddr];
	end

	logic [ROW_W-1:0] rd_row;
	logic [SW-1:0]    rd_link;
	logic [LW-1:0]    rd_len;
	assign rd_row  = rd_q[ROW_W-1:0];
	assign rd_link = rd_q[ROW_W +: SW];
	assign rd_len  = rd_q[ROW_W+SW +: LW];

	sam_state_t st_q, st_d;

	logic [SYM_W-1:0]  c_q, c_d;
	logic [CW-1:0]     used_q, used_d;
	logic [SW-1:0]     last_q, last_d;
	logic [LW-1:0]     lastlen_q, lastlen_d;
	logic [DISTINCT_W-1:0] distinct_q, distinct_d;
	logic [SW-1:0]     qs_q, qs_d;
	logic [QLEN_W-1:0] ql_q, ql_d;
	logic              qfirst_q, qfirst_d;
	logic              full_q, full_d;
	logic [SW-1:0]     cur_q, cur_d, p_q, p_d, qn_q, qn_d, clone_q, clone_d, link_q, link_d;
	logic [LW-1:0]     plen_q, plen_d, curlen_q, curlen_d, linklen_q, linklen_d;

	// symbol index and selected entry of the row just read
	logic [8:0]    c9, in9;
	logic [AW-1:0] idx;
	logic [EW-1:0] ent;
	logic          ent_vld;
	logic [SW-1:0] ent_tgt;
	assign c9      = {2'b00, c_q};
	assign in9     = {2'b00, in_ch.symbol};
	assign idx     = c9[AW-1:0];
	assign ent     = rd_row[int'(idx)*EW +: EW];
	assign ent_vld = ent[SW];
	assign ent_tgt = ent[SW-1:0];

	trk_ctl_t          trk;
	logic [QLEN_W-1:0] best;
	logic [QPOS_W-1:0] best_pos;

	sam_query_track u_trk (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (trk),
		.best     (best),
		.best_pos (best_pos)
	);

	logic ov_q, load;
	logic [COUNT_W-1:0]    oc_q;
	logic [DISTINCT_W-1:0] od_q;
	logic [QLEN_W-1:0]     om_q, ob_q;
	logic [QPOS_W-1:0]     oe_q;
	logic                  of_q;

	assign in_ch.ready = (st_q == S_IDLE);

	always_comb begin
		logic [ROW_W-1:0]  row;
		logic [QLEN_W-1:0] l;
		row        = rd_row;
		l          = '0;
		st_d       = st_q;
		c_d        = c_q;
		used_d     = used_q;
		last_d     = last_q;
		lastlen_d  = lastlen_q;
		distinct_d = distinct_q;
		qs_d       = qs_q;
		ql_d       = ql_q;
		qfirst_d   = qfirst_q;
		full_d     = full_q;
		cur_d      = cur_q;
		p_d        = p_q;
		qn_d       = qn_q;
		clone_d    = clone_q;
		link_d     = link_q;
		plen_d     = plen_q;
		curlen_d   = curlen_q;
		linklen_d  = linklen_q;
		we         = 1'b0;
		re         = 1'b0;
		waddr      = '0;
		raddr      = '0;
		wdata      = '0;
		trk        = '0;
		load       = 1'b0;
		case (st_q)
			S_INIT: begin
				// root record, row all empty
				we   = 1'b1;
				st_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_ch.valid) begin
					c_d    = in_ch.symbol;
					full_d = 1'b0;
					st_d   = S_RES;
					case (action_t'(in_ch.action))
						ACT_CLEAR: begin
							we         = 1'b1;
							used_d     = CW'(1);
							last_d     = '0;
							lastlen_d  = '0;
							distinct_d = '0;
							qs_d       = '0;
							ql_d       = '0;
							trk.clr    = 1'b1;
						end
						ACT_EXTEND: begin
							if (in9 < ALPHA9)
								st_d = S_ECHK;
						end
						ACT_QSTART: begin
							qs_d    = '0;
							ql_d    = '0;
							trk.clr = 1'b1;
						end
						ACT_QSYM: begin
							if (in9 < ALPHA9) begin
								re       = 1'b1;
								raddr    = qs_q;
								qfirst_d = 1'b1;
								st_d     = S_QWALK;
							end else begin
								qs_d    = '0;
								ql_d    = '0;
								trk.upd = 1'b1;
							end
						end
						default: st_d = S_RES;
					endcase
				end
			end
			S_ECHK: begin
				if (lastlen_q >= LW'(MAX_LEN) ||
					(CW+1)'(used_q) + (CW+1)'(2) > (CW+1)'(NSTATES)) begin
					full_d = 1'b1;
					st_d   = S_RES;
				end else begin
					cur_d    = used_q[SW-1:0];
					used_d   = used_q + 1'b1;
					curlen_d = lastlen_q + 1'b1;
					p_d      = last_q;
					re       = 1'b1;
					raddr    = last_q;
					st_d     = S_EWALK;
				end
			end
			S_EWALK: begin
				if (ent_vld) begin
					plen_d = rd_len;
					qn_d   = ent_tgt;
					re     = 1'b1;
					raddr  = ent_tgt;
					st_d   = S_EQ;
				end else begin
					// add transition to the new state
					row[int'(idx)*EW +: EW] = {1'b1, cur_q};
					we    = 1'b1;
					waddr = p_q;
					wdata = {rd_len, rd_link, row};
					if (p_q == '0) begin
						link_d    = '0;
						linklen_d = '0;
						st_d      = S_EFIN;
					end else begin
						p_d   = rd_link;
						re    = 1'b1;
						raddr = rd_link;
					end
				end
			end
			S_EQ: begin
				if (plen_q + 1'b1 == rd_len) begin
					link_d    = qn_q;
					linklen_d = rd_len;
					st_d      = S_EFIN;
				end else begin
					// clone takes q's row and link
					clone_d = used_q[SW-1:0];
					used_d  = used_q + 1'b1;
					we      = 1'b1;
					waddr   = used_q[SW-1:0];
					wdata   = {plen_q + 1'b1, rd_link, rd_row};
					st_d    = S_EQL;
				end
			end
			S_EQL: begin
				// q now links to the clone, record still held in rd_q
				we    = 1'b1;
				waddr = qn_q;
				wdata = {rd_len, clone_q, rd_row};
				re    = 1'b1;
				raddr = p_q;
				st_d  = S_ECW;
			end
			S_ECW: begin
				if (ent_vld && ent_tgt == qn_q) begin
					row[int'(idx)*EW +: EW] = {1'b1, clone_q};
					we    = 1'b1;
					waddr = p_q;
					wdata = {rd_len, rd_link, row};
					if (p_q == '0) begin
						link_d    = clone_q;
						linklen_d = plen_q + 1'b1;
						st_d      = S_EFIN;
					end else begin
						p_d   = rd_link;
						re    = 1'b1;
						raddr = rd_link;
					end
				end else begin
					link_d    = clone_q;
					linklen_d = plen_q + 1'b1;
					st_d      = S_EFIN;
				end
			end
			S_EFIN: begin
				// new state with an empty row
				we         = 1'b1;
				waddr      = cur_q;
				wdata      = {curlen_q, link_q, {ROW_W{1'b0}}};
				last_d     = cur_q;
				lastlen_d  = curlen_q;
				distinct_d = distinct_q + DISTINCT_W'(curlen_q - linklen_q);
				st_d       = S_RES;
			end
			S_QWALK: begin
				if (ent_vld) begin
					l       = qfirst_q ? ql_q + 1'b1 : QLEN_W'(rd_len + 1'b1);
					qs_d    = ent_tgt;
					ql_d    = l;
					trk.upd = 1'b1;
					trk.len = l;
					st_d    = S_RES;
				end else if (qs_q == '0) begin
					qs_d    = '0;
					ql_d    = '0;
					trk.upd = 1'b1;
					st_d    = S_RES;
				end else begin
					qs_d     = rd_link;
					qfirst_d = 1'b0;
					re       = 1'b1;
					raddr    = rd_link;
				end
			end
			S_RES: begin
				if (!ov_q || out_ch.ready) begin
					load = 1'b1;
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_INIT;
			used_q     <= CW'(1);
			last_q     <= '0;
			lastlen_q  <= '0;
			distinct_q <= '0;
			qs_q       <= '0;
			ql_q       <= '0;
			qfirst_q   <= 1'b0;
			full_q     <= 1'b0;
			ov_q       <= 1'b0;
		end else begin
			st_q       <= st_d;
			used_q     <= used_d;
			last_q     <= last_d;
			lastlen_q  <= lastlen_d;
			distinct_q <= distinct_d;
			qs_q       <= qs_d;
			ql_q       <= ql_d;
			qfirst_q   <= qfirst_d;
			full_q     <= full_d;
			if (load)
				ov_q <= 1'b1;
			else if (out_ch.ready)
				ov_q <= 1'b0;
		end
	end

	// walk registers and result payload, no reset needed
	always_ff @(posedge clk) begin
		c_q       <= c_d;
		cur_q     <= cur_d;
		p_q       <= p_d;
		qn_q      <= qn_d;
		clone_q   <= clone_d;
		link_q    <= link_d;
		plen_q    <= plen_d;
		curlen_q  <= curlen_d;
		linklen_q <= linklen_d;
		if (load) begin
			oc_q <= COUNT_W'(used_q);
			od_q <= distinct_q;
			om_q <= ql_q;
			ob_q <= best;
			oe_q <= best_pos;
			of_q <= full_q;
		end
	end

	assign out_ch.valid          = ov_q;
	assign out_ch.state_count    = oc_q;
	assign out_ch.distinct_total = od_q;
	assign out_ch.match_length   = om_q;
	assign out_ch.best_length    = ob_q;
	assign out_ch.best_end       = oe_q;
	assign out_ch.table_full     = of_q;

endmodule

FILE: sv/sam_checker.sv
// ----------------------------------------------------------------------------
// sam_checker
// port level checks of the suffix automaton block, bound to the top level
// ----------------------------------------------------------------------------
module sam_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [sam_pkg::COUNT_W-1:0]    state_count,
	input logic [sam_pkg::DISTINCT_W-1:0] distinct_total,
	input logic [sam_pkg::QLEN_W-1:0]     match_length,
	input logic [sam_pkg::QLEN_W-1:0]     best_length
);
	import sam_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(state_count) && $stable(distinct_total))
		else $error("stalled result changed");

	a_root: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_count != '0)
		else $error("state count lost the root");

	a_best: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> best_length >= match_length)
		else $error("best length below current match");

endmodule

bind suffix_automaton_build_and_match sam_checker u_sam_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.state_count    (out_ch.state_count),
	.distinct_total (out_ch.distinct_total),
	.match_length   (out_ch.match_length),
	.best_length    (out_ch.best_length)
);
